FILE: design/salcd_pkg.sv
// Shared field widths and item kind codes of the cache tag directory.
package salcd_pkg;

   localparam int KIND_W = 2;
   localparam int WAY_W  = 2;
   localparam int ADDR_W = 40;
   localparam int CNT_W  = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_DIRTY  = 2'd1,
      KIND_FILL   = 2'd2
   } kind_type;

endpackage

FILE: design/salcd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module salcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/set_assoc_lru_cache_directory.sv
// Tag directory of a set-associative cache with true LRU order per set.
// Items: a lookup miss or no-op item only scans the set; a hit, mark-dirty and fill also sweep
// the set to update it; one item at a time, req_stall stays high from accept until the result loads.
// Rate is set by the single directory RAM: one way read per cycle to scan the set, then one
// way read and rewritten per cycle to update ranks and marks.
// Reset: synchronous; a clearing pass then writes every directory entry while req_stall stays
// high.
module set_assoc_lru_cache_directory #(
   parameter int OFFSET_BITS = 12,
   parameter int SET_BITS    = 8,
   parameter int WAYS        = 4,
   parameter int ADDR_BITS   = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [salcd_pkg::KIND_W-1:0]  req_kind,
   input  logic [salcd_pkg::ADDR_W-1:0]  req_address,
   input  logic [salcd_pkg::WAY_W-1:0]   req_way,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [salcd_pkg::WAY_W-1:0]   rsp_chosen_way,
   output logic                          rsp_chosen_valid,
   output logic                          rsp_chosen_dirty,
   output logic [salcd_pkg::ADDR_W-1:0]  rsp_victim_address,
   output logic [salcd_pkg::CNT_W-1:0]   rsp_hits_so_far,
   output logic [salcd_pkg::CNT_W-1:0]   rsp_misses_so_far
);

   import salcd_pkg::*;

   localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int TAG_RAW   = EFF_BITS - OFFSET_BITS - SET_BITS;
   localparam int TAG_WIDTH = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int WIDX      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RBITS     = WIDX;
   localparam int CBITS     = $clog2(WAYS + 1);
   localparam int AW        = SET_BITS + WIDX;
   localparam int DEPTH     = 1 << AW;
   localparam int CMPW      = (WIDX > WAY_W) ? WIDX : WAY_W;

   localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);
   localparam logic [RBITS-1:0]  LRU_RANK  = RBITS'(WAYS - 1);
   localparam logic [CBITS-1:0]  LAST_CNT  = CBITS'(WAYS);

   typedef struct packed {
      logic [TAG_WIDTH-1:0] tag;
      logic                 valid;
      logic                 dirty;
      logic [RBITS-1:0]     rank;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_WIDTH-1:0] tag,
                                                   input logic [SET_BITS-1:0] set);
      logic [ADDR_W-1:0] a;
      a = (ADDR_W'(tag) << (OFFSET_BITS + SET_BITS)) | (ADDR_W'(set) << OFFSET_BITS);
      return a & ADDR_MASK;
   endfunction

   state_type state_ff, state_in;
   logic [CBITS-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [SET_BITS-1:0]   set_ff, set_in;
   logic [TAG_WIDTH-1:0]  tag_ff, tag_in;
   logic [WAY_W-1:0]      way_ff, way_in;

   logic                  found_ff, found_in;
   logic [WIDX-1:0]       best_ff, best_in;
   logic [RBITS-1:0]      best_rank_ff, best_rank_in;
   logic                  best_dirty_ff, best_dirty_in;
   logic [WIDX-1:0]       lru_ff, lru_in;
   logic                  lru_valid_ff, lru_valid_in;
   logic                  lru_dirty_ff, lru_dirty_in;
   logic [TAG_WIDTH-1:0]  lru_tag_ff, lru_tag_in;
   logic                  gw_valid_ff, gw_valid_in;
   logic                  gw_dirty_ff, gw_dirty_in;
   logic [TAG_WIDTH-1:0]  gw_tag_ff, gw_tag_in;
   logic [RBITS-1:0]      gw_rank_ff, gw_rank_in;

   logic [WIDX-1:0]       target_ff, target_in;
   logic [RBITS-1:0]      old_rank_ff, old_rank_in;
   logic                  mru_ff, mru_in;
   logic                  fill_ff, fill_in;
   logic                  mark_ff, mark_in;

   logic [CNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]      miss_cnt_ff, miss_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [WAY_W-1:0]      rsp_way_ff, rsp_way_in;
   logic                  rsp_cvalid_ff, rsp_cvalid_in;
   logic                  rsp_cdirty_ff, rsp_cdirty_in;
   logic [ADDR_W-1:0]     rsp_vaddr_ff, rsp_vaddr_in;
   logic [CNT_W-1:0]      rsp_hits_ff, rsp_hits_in;
   logic [CNT_W-1:0]      rsp_misses_ff, rsp_misses_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [EW-1:0]         ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [EW-1:0]         ram_rdata;

   logic                  o_hit;
   logic [WAY_W-1:0]      o_way;
   logic                  o_valid;
   logic                  o_dirty;
   logic [ADDR_W-1:0]     o_vaddr;
   logic                  o_upd;
   logic [WIDX-1:0]       o_target;
   logic [RBITS-1:0]      o_old_rank;
   logic                  o_mru;
   logic                  o_fill;
   logic                  o_mark;
   logic                  o_hit_inc;
   logic                  o_miss_inc;

   logic [ADDR_W-1:0]     addr_m;
   logic [CBITS-1:0]      cnt_prev;
   logic [WIDX-1:0]       idx_prev;
   entry_type             rd_entry;
   entry_type             wr_entry;
   logic                  out_free;

   salcd_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign addr_m   = req_address & ADDR_MASK;
   assign cnt_prev = cnt_ff - CBITS'(1);
   assign idx_prev = cnt_prev[WIDX-1:0];
   assign rd_entry = entry_type'(ram_rdata);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // outcome of the item from the scan results
   always_comb begin
      o_hit      = 1'b0;
      o_way      = '0;
      o_valid    = 1'b0;
      o_dirty    = 1'b0;
      o_vaddr    = '0;
      o_upd      = 1'b0;
      o_target   = best_ff;
      o_old_rank = best_rank_ff;
      o_mru      = 1'b0;
      o_fill     = 1'b0;
      o_mark     = 1'b0;
      o_hit_inc  = 1'b0;
      o_miss_inc = 1'b0;
      case (kind_ff) inside
         KIND_LOOKUP: begin
            if (found_ff) begin
               o_hit     = 1'b1;
               o_way     = WAY_W'(best_ff);
               o_valid   = 1'b1;
               o_dirty   = best_dirty_ff;
               o_vaddr   = {ADDR_W{1'b1}};
               o_upd     = 1'b1;
               o_mru     = 1'b1;
               o_hit_inc = 1'b1;
            end else begin
               o_way      = WAY_W'(lru_ff);
               o_valid    = lru_valid_ff;
               o_dirty    = lru_dirty_ff;
               o_vaddr    = line_addr(lru_tag_ff, set_ff);
               o_miss_inc = 1'b1;
            end
         end
         KIND_DIRTY, KIND_FILL: begin
            o_way = way_ff;
            if (int'(way_ff) < WAYS) begin
               o_valid    = gw_valid_ff;
               o_dirty    = gw_dirty_ff;
               o_vaddr    = line_addr(gw_tag_ff, set_ff);
               o_upd      = 1'b1;
               o_target   = WIDX'(way_ff);
               o_old_rank = gw_rank_ff;
               o_mru      = (kind_ff == KIND_FILL);
               o_fill     = (kind_ff == KIND_FILL);
               o_mark     = (kind_ff == KIND_DIRTY);
            end
         end
         default: begin
            o_way = '0;
         end
      endcase
   end

   // rewrite of one way during the update sweep
   always_comb begin
      wr_entry = rd_entry;
      if (mru_ff) begin
         if (idx_prev == target_ff) begin
            wr_entry.rank = '0;
         end else if (rd_entry.rank < old_rank_ff) begin
            wr_entry.rank = RBITS'(rd_entry.rank + RBITS'(1));
         end
      end
      if (idx_prev == target_ff) begin
         if (fill_ff) begin
            wr_entry.tag   = tag_ff;
            wr_entry.valid = 1'b1;
            wr_entry.dirty = 1'b0;
         end
         if (mark_ff) begin
            wr_entry.dirty = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      way_in        = way_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_rank_in  = best_rank_ff;
      best_dirty_in = best_dirty_ff;
      lru_in        = lru_ff;
      lru_valid_in  = lru_valid_ff;
      lru_dirty_in  = lru_dirty_ff;
      lru_tag_in    = lru_tag_ff;
      gw_valid_in   = gw_valid_ff;
      gw_dirty_in   = gw_dirty_ff;
      gw_tag_in     = gw_tag_ff;
      gw_rank_in    = gw_rank_ff;
      target_in     = target_ff;
      old_rank_in   = old_rank_ff;
      mru_in        = mru_ff;
      fill_in       = fill_ff;
      mark_in       = mark_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_way_in    = rsp_way_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_cdirty_in = rsp_cdirty_ff;
      rsp_vaddr_in  = rsp_vaddr_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_misses_in = rsp_misses_ff;
      ram_we        = 1'b0;
      ram_waddr     = {set_ff, idx_prev};
      ram_wdata     = EW'(wr_entry);
      ram_raddr     = {set_ff, cnt_ff[WIDX-1:0]};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = EW'(entry_type'{
               tag:   '0,
               valid: 1'b0,
               dirty: 1'b0,
               rank:  RBITS'(WAYS - 1 - int'(clr_ff[WIDX-1:0]))
            });
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               set_in   = SET_BITS'(addr_m >> OFFSET_BITS);
               tag_in   = TAG_WIDTH'(addr_m >> (OFFSET_BITS + SET_BITS));
               way_in   = req_way;
               found_in = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               if (rd_entry.valid && rd_entry.tag == tag_ff &&
                   (!found_ff || rd_entry.rank < best_rank_ff)) begin
                  found_in      = 1'b1;
                  best_in       = idx_prev;
                  best_rank_in  = rd_entry.rank;
                  best_dirty_in = rd_entry.dirty;
               end
               if (idx_prev == '0 || rd_entry.rank == LRU_RANK) begin
                  lru_in       = idx_prev;
                  lru_valid_in = rd_entry.valid;
                  lru_dirty_in = rd_entry.dirty;
                  lru_tag_in   = rd_entry.tag;
               end
               if (CMPW'(idx_prev) == CMPW'(way_ff)) begin
                  gw_valid_in = rd_entry.valid;
                  gw_dirty_in = rd_entry.dirty;
                  gw_tag_in   = rd_entry.tag;
                  gw_rank_in  = rd_entry.rank;
               end
            end
            cnt_in = cnt_ff + CBITS'(1);
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            target_in   = o_target;
            old_rank_in = o_old_rank;
            mru_in      = o_mru;
            fill_in     = o_fill;
            mark_in     = o_mark;
            if (o_hit_inc) begin
               hit_cnt_in = hit_cnt_ff + CNT_W'(1);
            end
            if (o_miss_inc) begin
               miss_cnt_in = miss_cnt_ff + CNT_W'(1);
            end
            cnt_in   = '0;
            state_in = o_upd ? ST_UPDATE : ST_DONE;
         end
         ST_UPDATE: begin
            ram_we = (cnt_ff != '0);
            cnt_in = cnt_ff + CBITS'(1);
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = o_hit;
               rsp_way_in    = o_way;
               rsp_cvalid_in = o_valid;
               rsp_cdirty_in = o_dirty;
               rsp_vaddr_in  = o_vaddr;
               rsp_hits_in   = hit_cnt_ff;
               rsp_misses_in = miss_cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         clr_ff        <= clr_in;
         kind_ff       <= kind_in;
         set_ff        <= set_in;
         tag_ff        <= tag_in;
         way_ff        <= way_in;
         found_ff      <= found_in;
         best_ff       <= best_in;
         best_rank_ff  <= best_rank_in;
         best_dirty_ff <= best_dirty_in;
         lru_ff        <= lru_in;
         lru_valid_ff  <= lru_valid_in;
         lru_dirty_ff  <= lru_dirty_in;
         lru_tag_ff    <= lru_tag_in;
         gw_valid_ff   <= gw_valid_in;
         gw_dirty_ff   <= gw_dirty_in;
         gw_tag_ff     <= gw_tag_in;
         gw_rank_ff    <= gw_rank_in;
         target_ff     <= target_in;
         old_rank_ff   <= old_rank_in;
         mru_ff        <= mru_in;
         fill_ff       <= fill_in;
         mark_ff       <= mark_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_way_ff    <= rsp_way_in;
         rsp_cvalid_ff <= rsp_cvalid_in;
         rsp_cdirty_ff <= rsp_cdirty_in;
         rsp_vaddr_ff  <= rsp_vaddr_in;
         rsp_hits_ff   <= rsp_hits_in;
         rsp_misses_ff <= rsp_misses_in;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_chosen_way     = rsp_way_ff;
   assign rsp_chosen_valid   = rsp_cvalid_ff;
   assign rsp_chosen_dirty   = rsp_cdirty_ff;
   assign rsp_victim_address = rsp_vaddr_ff;
   assign rsp_hits_so_far    = rsp_hits_ff;
   assign rsp_misses_so_far  = rsp_misses_ff;

endmodule

FILE: design/salcd_checker.sv
// Port-level assertions for the cache tag directory and their bind to the top level.
module salcd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [salcd_pkg::KIND_W-1:0]  req_kind,
   input logic [salcd_pkg::ADDR_W-1:0]  req_address,
   input logic [salcd_pkg::WAY_W-1:0]   req_way,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_hit,
   input logic [salcd_pkg::WAY_W-1:0]   rsp_chosen_way,
   input logic                          rsp_chosen_valid,
   input logic                          rsp_chosen_dirty,
   input logic [salcd_pkg::ADDR_W-1:0]  rsp_victim_address,
   input logic [salcd_pkg::CNT_W-1:0]   rsp_hits_so_far,
   input logic [salcd_pkg::CNT_W-1:0]   rsp_misses_so_far
);

   import salcd_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("directory ready right after accepting an item");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_kind) &&
         $stable(req_address) && $stable(req_way)))
      else $error("stalled request item changed");

   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> rsp_chosen_valid)
      else $error("hit reported on an invalid way");

   a_hit_victim_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_victim_address == {ADDR_W{1'b1}}))
      else $error("hit with a victim address other than all ones");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit) &&
         $stable(rsp_chosen_way) && $stable(rsp_chosen_valid) &&
         $stable(rsp_chosen_dirty) && $stable(rsp_victim_address) &&
         $stable(rsp_hits_so_far) && $stable(rsp_misses_so_far)))
      else $error("stalled result item changed");

endmodule

bind set_assoc_lru_cache_directory salcd_checker u_salcd_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the set-associative LRU cache tag directory.
`timescale 1ns / 1ps

module testbench;
   import salcd_pkg::*;

   localparam int OFFSET_BITS = 12;
   localparam int SET_BITS    = 8;
   localparam int WAYS        = 4;
   localparam int SETS        = 1 << SET_BITS;
   localparam int TAG_W       = ADDR_W - OFFSET_BITS - SET_BITS;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_CYCLES = 3 * WAYS + 8;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [WAY_W-1:0]  way;
   } access_type;

   typedef struct packed {
      logic              hit;
      logic [WAY_W-1:0]  way;
      logic              valid;
      logic              dirty;
      logic [ADDR_W-1:0] victim;
      logic [CNT_W-1:0]  hits;
      logic [CNT_W-1:0]  misses;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic [WAY_W-1:0] req_way = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [WAY_W-1:0] rsp_chosen_way;
   logic rsp_chosen_valid;
   logic rsp_chosen_dirty;
   logic [ADDR_W-1:0] rsp_victim_address;
   logic [CNT_W-1:0] rsp_hits_so_far;
   logic [CNT_W-1:0] rsp_misses_so_far;

   set_assoc_lru_cache_directory i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_way            (req_way),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_chosen_way     (rsp_chosen_way),
      .rsp_chosen_valid   (rsp_chosen_valid),
      .rsp_chosen_dirty   (rsp_chosen_dirty),
      .rsp_victim_address (rsp_victim_address),
      .rsp_hits_so_far    (rsp_hits_so_far),
      .rsp_misses_so_far  (rsp_misses_so_far)
   );

   // directory state as the block should hold it
   logic [TAG_W-1:0] tag_mem   [SETS][WAYS];
   logic             valid_mem [SETS][WAYS];
   logic             dirty_mem [SETS][WAYS];
   logic [WAY_W-1:0] rank_mem  [SETS][WAYS];
   logic [CNT_W-1:0] hit_total = '0;
   logic [CNT_W-1:0] miss_total = '0;

   access_type  access_queue[$];
   outcome_type outcome_queue[$];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int cycle_count = 0;
   int results_seen = 0;
   int fail_count = 0;
   int lookup_hits = 0, lookup_misses = 0, fills_done = 0, dirty_marks = 0, unknown_kinds = 0;
   int hold_left = 0;
   logic held_off = 1'b0;
   logic quiet;

   assign quiet = cycle_count >= 8000 && cycle_count < 14000;

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   function automatic void promote_way(input logic [SET_BITS-1:0] set,
                                       input logic [WAY_W-1:0] w);
      logic [WAY_W-1:0] old;
      old = rank_mem[set][w];
      for (int k = 0; k < WAYS; k++)
         if (rank_mem[set][k] < old)
            rank_mem[set][k] = rank_mem[set][k] + 1'b1;
      rank_mem[set][w] = '0;
   endfunction

   function automatic outcome_type resolve_access(input logic [KIND_W-1:0] kind,
                                                  input logic [ADDR_W-1:0] address,
                                                  input logic [WAY_W-1:0] way);
      outcome_type o;
      logic [SET_BITS-1:0] set;
      logic [TAG_W-1:0] tag;
      logic found;
      logic [WAY_W-1:0] best;
      o = '0;
      set = address[OFFSET_BITS +: SET_BITS];
      tag = address[ADDR_W-1 -: TAG_W];
      found = 1'b0;
      best = '0;
      if (kind == KIND_LOOKUP) begin
         for (int w = 0; w < WAYS; w++) begin
            if (valid_mem[set][w] && tag_mem[set][w] == tag) begin
               if (!found || rank_mem[set][w] < rank_mem[set][best])
                  best = WAY_W'(w);
               found = 1'b1;
            end
         end
         if (found) begin
            o.hit = 1'b1;
            o.valid = 1'b1;
            o.dirty = dirty_mem[set][best];
            o.victim = '1;
            promote_way(set, best);
            hit_total = hit_total + 1'b1;
            lookup_hits++;
         end else begin
            for (int w = 0; w < WAYS; w++)
               if (rank_mem[set][w] == WAY_W'(WAYS - 1))
                  best = WAY_W'(w);
            o.valid = valid_mem[set][best];
            o.dirty = dirty_mem[set][best];
            o.victim = {tag_mem[set][best], set, {OFFSET_BITS{1'b0}}};
            miss_total = miss_total + 1'b1;
            lookup_misses++;
         end
         o.way = best;
      end else if (kind == KIND_DIRTY || kind == KIND_FILL) begin
         o.way = way;
         o.valid = valid_mem[set][way];
         o.dirty = dirty_mem[set][way];
         o.victim = {tag_mem[set][way], set, {OFFSET_BITS{1'b0}}};
         if (kind == KIND_DIRTY) begin
            dirty_mem[set][way] = 1'b1;
            dirty_marks++;
         end else begin
            tag_mem[set][way] = tag;
            valid_mem[set][way] = 1'b1;
            dirty_mem[set][way] = 1'b0;
            promote_way(set, way);
            fills_done++;
         end
      end else begin
         unknown_kinds++;
      end
      o.hits = hit_total;
      o.misses = miss_total;
      return o;
   endfunction

   function automatic logic [ADDR_W-1:0] join_address(input logic [TAG_W-1:0] tag,
                                                      input logic [SET_BITS-1:0] set,
                                                      input logic [OFFSET_BITS-1:0] offset);
      return {tag, set, offset};
   endfunction

   task automatic queue_access(input logic [KIND_W-1:0] kind,
                               input logic [ADDR_W-1:0] address,
                               input logic [WAY_W-1:0] way);
      access_queue.push_back('{kind: kind, address: address, way: way});
   endtask

   always @(posedge clock) begin : watch_ports
      outcome_type got, want;
      cycle_count++;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (rsp_fire) begin
         results_seen++;
         got = '{hit: rsp_hit, way: rsp_chosen_way, valid: rsp_chosen_valid,
                 dirty: rsp_chosen_dirty, victim: rsp_victim_address,
                 hits: rsp_hits_so_far, misses: rsp_misses_so_far};
         if (outcome_queue.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = outcome_queue.pop_front();
            check_field("hit", 64'(got.hit), 64'(want.hit));
            check_field("chosen_way", 64'(got.way), 64'(want.way));
            check_field("chosen_valid", 64'(got.valid), 64'(want.valid));
            check_field("chosen_dirty", 64'(got.dirty), 64'(want.dirty));
            check_field("victim_address", 64'(got.victim), 64'(want.victim));
            check_field("hits_so_far", 64'(got.hits), 64'(want.hits));
            check_field("misses_so_far", 64'(got.misses), 64'(want.misses));
         end
      end
      if (req_fire)
         outcome_queue.push_back(resolve_access(req_kind, req_address, req_way));
   end

   always @(negedge clock) begin : drive_requests
      access_type next_access;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (access_queue.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
            next_access = access_queue.pop_front();
            req_valid <= 1'b1;
            req_kind <= next_access.kind;
            req_address <= next_access.address;
            req_way <= next_access.way;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!held_off && results_seen >= 400) begin
         held_off <= 1'b1;
         hold_left <= 250;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 14);
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : run_test
      logic [SET_BITS-1:0] set_pool[6];
      logic [TAG_W-1:0] tag_pool[5];
      logic [ADDR_W-1:0] addr;
      int pick;
      for (int s = 0; s < SETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            tag_mem[s][w] = '0;
            valid_mem[s][w] = 1'b0;
            dirty_mem[s][w] = 1'b0;
            rank_mem[s][w] = WAY_W'(WAYS - 1 - w);
         end
      end

      // directed: empty sets, hits, dirty marks, duplicate tags, unknown kind
      queue_access(KIND_LOOKUP, '0, 2'd0);
      queue_access(KIND_LOOKUP, '1, 2'd3);
      queue_access(KIND_FILL, join_address('0, '0, '1), 2'd0);
      queue_access(KIND_LOOKUP, join_address('0, '0, 12'h5a5), 2'd3);
      queue_access(KIND_DIRTY, join_address('0, '0, '0), 2'd0);
      queue_access(KIND_LOOKUP, join_address('0, '0, '0), 2'd2);
      queue_access(KIND_FILL, join_address('0, '0, 12'h010), 2'd1);
      queue_access(KIND_LOOKUP, join_address('0, '0, '0), 2'd0);
      queue_access(KIND_LOOKUP, join_address(20'h12345, '0, '0), 2'd1);
      queue_access(KIND_DIRTY, join_address(20'h77777, '0, '0), 2'd3);
      queue_access(KIND_FILL, join_address(20'h12345, '0, '0), 2'd2);
      queue_access(KIND_DIRTY, join_address(20'h12345, '0, '0), 2'd2);
      queue_access(KIND_FILL, join_address(20'hab0cd, '0, '0), 2'd3);
      queue_access(KIND_LOOKUP, join_address(20'h55555, '0, '1), 2'd0);
      queue_access(KIND_LOOKUP, join_address(20'hab0cd, '0, '0), 2'd0);
      queue_access(KIND_UNKNOWN, '1, 2'd3);
      queue_access(KIND_FILL, '1, 2'd3);
      queue_access(KIND_LOOKUP, '1, 2'd0);
      queue_access(KIND_DIRTY, '1, 2'd2);
      queue_access(KIND_LOOKUP, join_address(20'h00001, '1, '0), 2'd1);
      queue_access(KIND_UNKNOWN, '0, 2'd0);
      queue_access(KIND_DIRTY, '1, 2'd3);
      queue_access(KIND_LOOKUP, '1, 2'd1);

      // random: a few hot sets and tags so lines collide, hit and get evicted
      set_pool[0] = '0;
      set_pool[1] = '1;
      for (int i = 2; i < 6; i++)
         set_pool[i] = SET_BITS'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 5; i++)
         tag_pool[i] = TAG_W'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(99) < 10)
            addr = ADDR_W'({$urandom, $urandom});
         else
            addr = join_address(tag_pool[$urandom_range(4)], set_pool[$urandom_range(5)],
                                OFFSET_BITS'($urandom));
         pick = $urandom_range(99);
         if (pick < 50) begin
            queue_access(KIND_LOOKUP, addr, WAY_W'($urandom));
            if ($urandom_range(99) < 30) begin
               queue_access(KIND_FILL, addr, WAY_W'($urandom));
               n++;
            end
         end else if (pick < 72) begin
            queue_access(KIND_FILL, addr, WAY_W'($urandom));
         end else if (pick < 94) begin
            queue_access(KIND_DIRTY, addr, WAY_W'($urandom));
         end else begin
            queue_access(KIND_UNKNOWN, addr, WAY_W'($urandom));
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (access_queue.size() != 0 || req_valid)
         @(negedge clock);
      while (outcome_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (outcome_queue.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", outcome_queue.size()));

      $display("checked %0d results: %0d lookup hits, %0d lookup misses", results_seen,
               lookup_hits, lookup_misses);
      $display("also %0d fills, %0d dirty marks, %0d unknown kinds, %0d mismatches",
               fills_done, dirty_marks, unknown_kinds, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
